FILE: rtl/ehp_pkg.sv
// ----------------------------------------------------------------------------
// Ethernet/IPv4/L4 header parser package
// Item types, EtherType and protocol codes, and verdict codes.
// ----------------------------------------------------------------------------
package ehp_pkg;

  localparam int ARITH_W = 18;

  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] ETH_VLAN  = 16'h8100;
  localparam logic [15:0] ETH_ARP   = 16'h0806;
  localparam logic [15:0] ETH_RARP  = 16'h8035;
  localparam logic [15:0] ETH_IPV6  = 16'h86DD;
  localparam logic [15:0] ETH_EAPOL = 16'h888E;

  localparam logic [4:0] IP_OFS_PLAIN = 5'd14;
  localparam logic [4:0] IP_OFS_VLAN  = 5'd18;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [3:0] IP_VER4 = 4'd4;

  localparam logic [3:0] V_OK          = 4'd0;
  localparam logic [3:0] V_SHORT_ETH   = 4'd1;
  localparam logic [3:0] V_IGNORED     = 4'd2;
  localparam logic [3:0] V_UNKNOWN     = 4'd3;
  localparam logic [3:0] V_SHORT_IP    = 4'd4;
  localparam logic [3:0] V_NOT_V4      = 4'd5;
  localparam logic [3:0] V_SHORT_TCP   = 4'd6;
  localparam logic [3:0] V_SHORT_UDP   = 4'd7;
  localparam logic [3:0] V_ICMP        = 4'd8;
  localparam logic [3:0] V_OTHER       = 4'd9;
  localparam logic [3:0] V_SHORT_PAYLD = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic        is_tcp;
    logic [47:0] src_endpoint;
    logic [47:0] dst_endpoint;
    logic [7:0]  tcp_flags;
    logic [15:0] payload_offset;
  } out_item_t;

  typedef logic [15:0] cfg_word_t;

endpackage

FILE: rtl/ehp_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream channel
// One item moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface ehp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ethernet_ipv4_l4_header_parser_top.sv
// ----------------------------------------------------------------------------
// Ethernet/IPv4/L4 header parser
// Takes a frame byte by byte and gives one verdict item per frame.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                           per
//  in_if    in   data_byte, last_byte                              frame byte
//  out_if   out  verdict, is_tcp, src/dst_endpoint, tcp_flags,
//                payload_offset                                    frame
//  cfg_if   in   min_payload                                       write
//
//  One byte per cycle while no last byte waits on a full snapshot stage.
//  A last byte's accept edge loads the input register; the fields are then
//  captured into a frame snapshot, and the verdict is then loaded into the
//  output register.
//  Reset clears the min_payload register and all frame state.
//  A stalled output holds the snapshot stage; bytes keep flowing until a
//  second last byte meets the full snapshot stage.
// ----------------------------------------------------------------------------
module ethernet_ipv4_l4_header_parser_top #(
  parameter int MAX_FRAME_BYTES = 65535
) (
  input  logic clk,
  input  logic rst_n,
  ehp_stream_if.sink   in_if,
  ehp_stream_if.source out_if,
  ehp_stream_if.sink   cfg_if
);
  import ehp_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

  logic [15:0] min_payload_r;

  // input stage
  logic     v1_r;
  in_item_t in_r;

  // frame state
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      ek_r, ek_nxt;
  logic [4:0]       ips_r, ips_nxt;
  logic [7:0]       vl_r, vl_nxt;
  logic [7:0]       proto_r, proto_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [31:0]      dst_r, dst_nxt;
  logic [15:0]      sport_r, sport_nxt;
  logic [15:0]      dport_r, dport_nxt;
  logic [15:0]      tof_r, tof_nxt;

  // frame snapshot
  logic             v2_r;
  logic [CNT_W-1:0] s_len_r;
  logic [15:0]      s_ek_r;
  logic [4:0]       s_ips_r;
  logic [7:0]       s_vl_r;
  logic [7:0]       s_proto_r;
  logic [31:0]      s_src_r;
  logic [31:0]      s_dst_r;
  logic [15:0]      s_sport_r;
  logic [15:0]      s_dport_r;
  logic [15:0]      s_tof_r;

  // output
  logic      out_v_r;
  out_item_t out_r, out_nxt;

  logic out_free, adv1, adv2;

  assign out_free     = !out_v_r || out_if.ready;
  assign adv2         = v2_r && out_free;
  assign adv1         = v1_r && (!in_r.last_byte || !v2_r || adv2);
  assign in_if.ready  = !v1_r || adv1;
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_v_r;
  assign out_if.data  = out_r;

  // field capture
  always_comb begin
    logic [ARITH_W-1:0] i, p, t;
    logic [7:0]         b, vl_cur;
    i = ARITH_W'(cnt_r);
    p = ARITH_W'(ips_r);
    b = in_r.data_byte;
    cnt_nxt   = cnt_r;
    ek_nxt    = ek_r;
    ips_nxt   = ips_r;
    vl_nxt    = vl_r;
    proto_nxt = proto_r;
    src_nxt   = src_r;
    dst_nxt   = dst_r;
    sport_nxt = sport_r;
    dport_nxt = dport_r;
    tof_nxt   = tof_r;
    vl_cur    = (i == p) ? b : vl_r;
    t         = p + ARITH_W'({vl_cur[3:0], 2'b00});
    if (cnt_r < CNT_MAX) begin
      cnt_nxt = cnt_r + CNT_W'(1);
      if (i == ARITH_W'(12)) ek_nxt = {b, 8'h00};
      if (i == ARITH_W'(13)) begin
        ek_nxt  = {ek_r[15:8], b};
        ips_nxt = ({ek_r[15:8], b} == ETH_VLAN) ? IP_OFS_VLAN : IP_OFS_PLAIN;
      end
      if (i >= ARITH_W'(14)) begin
        if (i == p) vl_nxt = b;
        if (i == p + ARITH_W'(9)) proto_nxt = b;
        if (i >= p + ARITH_W'(12) && i < p + ARITH_W'(16)) src_nxt = {src_r[23:0], b};
        if (i >= p + ARITH_W'(16) && i < p + ARITH_W'(20)) dst_nxt = {dst_r[23:0], b};
        if (i >= t && i < t + ARITH_W'(2)) sport_nxt = {sport_r[7:0], b};
        if (i >= t + ARITH_W'(2) && i < t + ARITH_W'(4)) dport_nxt = {dport_r[7:0], b};
        if (i >= t + ARITH_W'(12) && i < t + ARITH_W'(14)) tof_nxt = {tof_r[7:0], b};
      end
    end
  end

  // verdict
  always_comb begin
    logic [ARITH_W-1:0] len, p, t, d;
    logic [3:0]         v;
    len = ARITH_W'(s_len_r);
    p   = ARITH_W'(s_ips_r);
    t   = p + ARITH_W'({s_vl_r[3:0], 2'b00});
    d   = '0;
    v   = V_OK;
    priority if (len < ARITH_W'(14)) begin
      v = V_SHORT_ETH;
    end else if (s_ek_r != ETH_IPV4 && s_ek_r != ETH_VLAN) begin
      if (s_ek_r == ETH_ARP || s_ek_r == ETH_RARP ||
          s_ek_r == ETH_IPV6 || s_ek_r == ETH_EAPOL) begin
        v = V_IGNORED;
      end else begin
        v = V_UNKNOWN;
      end
    end else if (len < p + ARITH_W'(20)) begin
      v = V_SHORT_IP;
    end else if (s_vl_r[7:4] != IP_VER4) begin
      v = V_NOT_V4;
    end else if (s_proto_r == PROTO_TCP) begin
      d = t + ARITH_W'({s_tof_r[15:12], 2'b00});
      if (len < t + ARITH_W'(20)) v = V_SHORT_TCP;
    end else if (s_proto_r == PROTO_UDP) begin
      d = t + ARITH_W'(8);
      if (len < t + ARITH_W'(8)) v = V_SHORT_UDP;
    end else if (s_proto_r == PROTO_ICMP) begin
      v = V_ICMP;
    end else begin
      v = V_OTHER;
    end
    if (v == V_OK && d + ARITH_W'(min_payload_r) > len) v = V_SHORT_PAYLD;

    out_nxt = '0;
    out_nxt.verdict = v;
    if (v == V_OK) begin
      out_nxt.is_tcp         = (s_proto_r == PROTO_TCP);
      out_nxt.src_endpoint   = {s_src_r, s_sport_r};
      out_nxt.dst_endpoint   = {s_dst_r, s_dport_r};
      out_nxt.tcp_flags      = (s_proto_r == PROTO_TCP) ? s_tof_r[7:0] : 8'h00;
      out_nxt.payload_offset = d[15:0];
    end
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_payload_r <= '0;
      v1_r          <= 1'b0;
      v2_r          <= 1'b0;
      out_v_r       <= 1'b0;
      cnt_r         <= '0;
      ek_r          <= '0;
      ips_r         <= '0;
      vl_r          <= '0;
      proto_r       <= '0;
      src_r         <= '0;
      dst_r         <= '0;
      sport_r       <= '0;
      dport_r       <= '0;
      tof_r         <= '0;
    end else begin
      if (cfg_if.valid) min_payload_r <= cfg_if.data;

      if (in_if.valid && in_if.ready) v1_r <= 1'b1;
      else if (adv1)                  v1_r <= 1'b0;

      if (adv1 && in_r.last_byte) v2_r <= 1'b1;
      else if (adv2)              v2_r <= 1'b0;

      if (adv2)              out_v_r <= 1'b1;
      else if (out_if.ready) out_v_r <= 1'b0;

      if (adv1) begin
        if (in_r.last_byte) begin
          cnt_r   <= '0;
          ek_r    <= '0;
          ips_r   <= '0;
          vl_r    <= '0;
          proto_r <= '0;
          src_r   <= '0;
          dst_r   <= '0;
          sport_r <= '0;
          dport_r <= '0;
          tof_r   <= '0;
        end else begin
          cnt_r   <= cnt_nxt;
          ek_r    <= ek_nxt;
          ips_r   <= ips_nxt;
          vl_r    <= vl_nxt;
          proto_r <= proto_nxt;
          src_r   <= src_nxt;
          dst_r   <= dst_nxt;
          sport_r <= sport_nxt;
          dport_r <= dport_nxt;
          tof_r   <= tof_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) in_r <= in_if.data;
    if (adv1 && in_r.last_byte) begin
      s_len_r   <= cnt_nxt;
      s_ek_r    <= ek_nxt;
      s_ips_r   <= ips_nxt;
      s_vl_r    <= vl_nxt;
      s_proto_r <= proto_nxt;
      s_src_r   <= src_nxt;
      s_dst_r   <= dst_nxt;
      s_sport_r <= sport_nxt;
      s_dport_r <= dport_nxt;
      s_tof_r   <= tof_nxt;
    end
    if (adv2) out_r <= out_nxt;
  end

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("byte count above frame limit");

  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.verdict != V_OK |->
      !out_r.is_tcp && out_r.src_endpoint == '0 && out_r.dst_endpoint == '0 &&
      out_r.tcp_flags == '0 && out_r.payload_offset == '0)
    else $error("failed verdict carries field data");

  a_flags_tcp: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.tcp_flags != '0 |-> out_r.is_tcp)
    else $error("tcp flags on non-TCP result");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv1 && in_r.last_byte |=> cnt_r == '0 && v2_r)
    else $error("last byte did not close the frame");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !adv2 |=> v2_r && $stable(s_len_r))
    else $error("frame snapshot overwritten while held");

endmodule

FILE: tb/sv/ethernet_ipv4_l4_header_parser_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Ethernet/IPv4/L4 header parser testbench
// Streams frames byte by byte into the parser with random gaps and output
// stalls, and predicts each frame's verdict to check every result.
// ----------------------------------------------------------------------------
module ethernet_ipv4_l4_header_parser_top_tb;
  import ehp_pkg::*;

  localparam int FRAME_MAX   = 65535;
  localparam int HOLD_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int RAND_BYTES  = 400;

  class frame_verdict_board;
    bit [31:0] min_pay;
    bit [31:0] n_seen;
    bit [31:0] eth_type;
    bit [31:0] ip_base;
    bit [31:0] ver_ihl;
    bit [31:0] proto;
    bit [31:0] saddr;
    bit [31:0] daddr;
    bit [31:0] sport;
    bit [31:0] dport;
    bit [31:0] l4_word;
    out_item_t verdicts_due[$];
    int errors;
    int results;

    function new();
      min_pay = 0;
      errors  = 0;
      results = 0;
      clear();
    endfunction

    function void clear();
      n_seen   = 0;
      eth_type = 0;
      ip_base  = 0;
      ver_ihl  = 0;
      proto    = 0;
      saddr    = 0;
      daddr    = 0;
      sport    = 0;
      dport    = 0;
      l4_word  = 0;
    endfunction

    function void set_min_payload(cfg_word_t v);
      min_pay = v;
    endfunction

    function int pending();
      return verdicts_due.size();
    endfunction

    function void grab(bit [31:0] i, bit [31:0] b);
      bit [31:0] p, vl, t;
      if (i == 12) eth_type = b << 8;
      if (i == 13) begin
        eth_type = (eth_type & 32'hFF00) | b;
        ip_base = (eth_type == ETH_VLAN) ? IP_OFS_VLAN : IP_OFS_PLAIN;
      end
      if (i < IP_OFS_PLAIN) return;
      p = ip_base;
      vl = (i == p) ? b : ver_ihl;
      if (i == p) ver_ihl = b;
      if (i == p + 9) proto = b;
      if (i >= p + 12 && i < p + 16) saddr = (saddr << 8) | b;
      if (i >= p + 16 && i < p + 20) daddr = (daddr << 8) | b;
      t = p + (vl & 15) * 4;
      if (i >= t && i < t + 2) sport = ((sport << 8) | b) & 32'hFFFF;
      if (i >= t + 2 && i < t + 4) dport = ((dport << 8) | b) & 32'hFFFF;
      if (i >= t + 12 && i < t + 14) l4_word = ((l4_word << 8) | b) & 32'hFFFF;
    endfunction

    function bit [3:0] judge(bit [31:0] len, output bit [31:0] d);
      bit [31:0] t;
      d = 0;
      if (len < IP_OFS_PLAIN) return V_SHORT_ETH;
      if (eth_type != ETH_IPV4 && eth_type != ETH_VLAN) begin
        if (eth_type == ETH_ARP || eth_type == ETH_RARP ||
            eth_type == ETH_IPV6 || eth_type == ETH_EAPOL)
          return V_IGNORED;
        return V_UNKNOWN;
      end
      if (len < ip_base + 20) return V_SHORT_IP;
      if ((ver_ihl >> 4) != IP_VER4) return V_NOT_V4;
      t = ip_base + (ver_ihl & 15) * 4;
      if (proto == PROTO_TCP) begin
        if (len < t + 20) return V_SHORT_TCP;
        d = t + ((l4_word >> 12) & 15) * 4;
      end else if (proto == PROTO_UDP) begin
        if (len < t + 8) return V_SHORT_UDP;
        d = t + 8;
      end else if (proto == PROTO_ICMP) begin
        return V_ICMP;
      end else begin
        return V_OTHER;
      end
      if (d + min_pay > len) return V_SHORT_PAYLD;
      return V_OK;
    endfunction

    function void take_byte(in_item_t it);
      bit [31:0] d;
      bit [3:0]  vd;
      out_item_t e;
      if (n_seen < FRAME_MAX) begin
        grab(n_seen, it.data_byte);
        n_seen++;
      end
      if (!it.last_byte) return;
      vd = judge(n_seen, d);
      e = '0;
      e.verdict = vd;
      if (vd == V_OK) begin
        e.is_tcp         = (proto == PROTO_TCP);
        e.src_endpoint   = {saddr, sport[15:0]};
        e.dst_endpoint   = {daddr, dport[15:0]};
        e.tcp_flags      = (proto == PROTO_TCP) ? l4_word[7:0] : 8'h00;
        e.payload_offset = d[15:0];
      end
      verdicts_due.push_back(e);
      clear();
    endfunction

    function void field_check(string name, logic [47:0] want, logic [47:0] seen);
      if (seen !== want) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, seen);
      end
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t e;
      if (verdicts_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual verdict %0h",
                 $time, got.verdict);
        return;
      end
      e = verdicts_due.pop_front();
      results++;
      field_check("verdict", e.verdict, got.verdict);
      field_check("is_tcp", e.is_tcp, got.is_tcp);
      field_check("src_endpoint", e.src_endpoint, got.src_endpoint);
      field_check("dst_endpoint", e.dst_endpoint, got.dst_endpoint);
      field_check("tcp_flags", e.tcp_flags, got.tcp_flags);
      field_check("payload_offset", e.payload_offset, got.payload_offset);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  ehp_stream_if #(.T(in_item_t))  in_if ();
  ehp_stream_if #(.T(out_item_t)) out_if ();
  ehp_stream_if #(.T(cfg_word_t)) cfg_if ();

  ethernet_ipv4_l4_header_parser_top #(
    .MAX_FRAME_BYTES(FRAME_MAX)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_if),
    .out_if(out_if),
    .cfg_if(cfg_if)
  );

  frame_verdict_board board = new();

  bit [7:0] frame_q[$];
  bit       hold_out;
  bit       rx_steady;
  int       quiet;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) board.set_min_payload(cfg_if.data);
      if (in_if.valid && in_if.ready) board.take_byte(in_if.data);
      if (out_if.valid && out_if.ready) board.check_verdict(out_if.data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_out) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out = 1'b0;
      end
      gap = rx_steady ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        out_if.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_if.ready = 1'b1;
      do @(posedge clk); while (!out_if.valid && !hold_out);
      @(negedge clk);
    end
  end

  task automatic push_rand(input int n);
    repeat (n) frame_q.push_back(8'($urandom));
  endtask

  task automatic push16(input bit [15:0] v);
    frame_q.push_back(v[15:8]);
    frame_q.push_back(v[7:0]);
  endtask

  task automatic trim_to(input int n);
    while (frame_q.size() > n) void'(frame_q.pop_back());
  endtask

  task automatic build_raw(input bit [15:0] etype, input int len);
    frame_q.delete();
    push_rand(12);
    push16(etype);
    if (len > frame_q.size()) push_rand(len - frame_q.size());
    trim_to(len);
  endtask

  task automatic build_ip(input bit vlan, input bit [15:0] inner, input bit [3:0] ver,
                          input bit [3:0] ihl, input bit [7:0] proto, input bit [3:0] doff,
                          input int pay, input int cut);
    bit [3:0] lo;
    lo = 4'($urandom);
    frame_q.delete();
    push_rand(12);
    if (vlan) begin
      push16(ETH_VLAN);
      push_rand(2);
      push16(inner);
    end else begin
      push16(ETH_IPV4);
    end
    frame_q.push_back({ver, ihl});
    push_rand(8);
    frame_q.push_back(proto);
    push_rand(10);
    if (ihl > 5) push_rand((ihl - 5) * 4);
    if (proto == PROTO_TCP) begin
      push_rand(12);
      frame_q.push_back({doff, lo});
      push_rand(7);
      if (doff > 5) push_rand((doff - 5) * 4);
    end else begin
      push_rand(8);
    end
    push_rand(pay);
    if (cut > 0) trim_to(cut);
  endtask

  task automatic build_random_frame();
    int r, pr, cut;
    bit vlan;
    bit [15:0] inner;
    bit [3:0] ver, ihl, doff;
    bit [7:0] proto;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      vlan  = ($urandom_range(0, 3) == 0);
      inner = ($urandom_range(0, 7) == 0) ? 16'($urandom) : ETH_IPV4;
      pr    = $urandom_range(0, 19);
      proto = (pr < 10) ? PROTO_TCP : (pr < 17) ? PROTO_UDP :
              (pr == 17) ? PROTO_ICMP : 8'($urandom);
      if (r < 60) begin
        ver  = IP_VER4;
        ihl  = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'd5;
        doff = ($urandom_range(0, 6) == 0) ? 4'($urandom) : 4'd5;
        cut  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 90) : 0;
      end else begin
        ver  = 4'($urandom);
        ihl  = 4'($urandom);
        doff = 4'($urandom);
        cut  = $urandom_range(1, 90);
      end
      build_ip(vlan, inner, ver, ihl, proto, doff, $urandom_range(0, 24), cut);
    end else if (r < 85) begin
      case ($urandom_range(0, 4))
        0: build_raw(ETH_ARP, $urandom_range(1, 70));
        1: build_raw(ETH_RARP, $urandom_range(1, 70));
        2: build_raw(ETH_IPV6, $urandom_range(1, 70));
        3: build_raw(ETH_EAPOL, $urandom_range(1, 70));
        default: build_raw(16'($urandom), $urandom_range(1, 70));
      endcase
    end else begin
      frame_q.delete();
      push_rand($urandom_range(1, 80));
    end
  endtask

  task automatic send_frame(input bit fast);
    int gap;
    foreach (frame_q[k]) begin
      gap = fast ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
        in_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_if.valid = 1'b1;
      in_if.data  = {frame_q[k], k == frame_q.size() - 1};
      do @(posedge clk); while (!in_if.ready);
      @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_min_payload(input cfg_word_t v);
    wait_idle();
    cfg_if.valid = 1'b1;
    cfg_if.data  = v;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic run_directed();
    build_raw(ETH_IPV4, 1);                                          send_frame(0);
    build_raw(ETH_IPV4, 13);                                         send_frame(0);
    build_raw(ETH_ARP, 60);                                          send_frame(0);
    build_raw(ETH_RARP, 42);                                         send_frame(0);
    build_raw(ETH_IPV6, 14);                                         send_frame(0);
    build_raw(ETH_EAPOL, 64);                                        send_frame(0);
    build_raw(16'h1234, 30);                                         send_frame(0);
    build_ip(0, 16'h0, IP_VER4, 4'd5, PROTO_TCP, 4'd5, 0, 33);       send_frame(0);
    build_ip(1, ETH_IPV4, IP_VER4, 4'd5, PROTO_UDP, 4'd5, 0, 37);    send_frame(0);
    build_ip(0, 16'h0, 4'd6, 4'd5, PROTO_TCP, 4'd5, 4, 0);           send_frame(0);
    build_ip(0, 16'h0, IP_VER4, 4'd5, PROTO_TCP, 4'd5, 0, 53);       send_frame(0);
    build_ip(0, 16'h0, IP_VER4, 4'd5, PROTO_UDP, 4'd5, 0, 41);       send_frame(0);
    build_ip(0, 16'h0, IP_VER4, 4'd5, PROTO_ICMP, 4'd5, 8, 0);       send_frame(0);
    build_ip(0, 16'h0, IP_VER4, 4'd5, 8'hFF, 4'd5, 8, 0);            send_frame(0);
    build_ip(0, 16'h0, IP_VER4, 4'd5, PROTO_TCP, 4'd15, 0, 54);      send_frame(0);
    build_ip(0, 16'h0, IP_VER4, 4'd5, PROTO_TCP, 4'd5, 10, 0);       send_frame(0);
    build_ip(1, ETH_IPV4, IP_VER4, 4'd5, PROTO_UDP, 4'd5, 0, 0);     send_frame(0);
    build_ip(1, ETH_IPV6, IP_VER4, 4'd5, PROTO_TCP, 4'd5, 6, 0);     send_frame(0);
    build_ip(0, 16'h0, IP_VER4, 4'd0, PROTO_TCP, 4'd5, 0, 0);        send_frame(0);
    build_ip(0, 16'h0, IP_VER4, 4'd15, PROTO_UDP, 4'd5, 3, 0);       send_frame(0);
    build_ip(0, 16'h0, IP_VER4, 4'd5, PROTO_TCP, 4'd0, 2, 0);        send_frame(0);
    frame_q.delete();
    repeat (64) frame_q.push_back(8'hFF);
    send_frame(0);
    frame_q.delete();
    repeat (60) frame_q.push_back(8'h00);
    send_frame(0);
  endtask

  initial begin
    int phase, nframes, rand_bytes;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    hold_out     = 1'b0;
    rx_steady    = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    write_min_payload(16'd0);
    run_directed();

    write_min_payload(16'hFFFF);
    build_random_frame();
    send_frame(0);

    phase = 0;
    rand_bytes = 0;
    while (phase < 3 || rand_bytes < RAND_BYTES) begin
      case ($urandom_range(0, 9))
        0: write_min_payload(16'd0);
        1: write_min_payload(16'hFFFF);
        default: write_min_payload(16'($urandom_range(0, 24)));
      endcase
      rx_steady = (phase == 2);
      if (phase == 0) hold_out = 1'b1;
      nframes = (phase == 0) ? 4 : 2;
      for (int f = 0; f < nframes; f++) begin
        if (phase == 1 && f == nframes / 2) wait_idle();
        build_random_frame();
        rand_bytes += frame_q.size();
        send_frame(phase == 0 || phase == 2 || $urandom_range(0, 5) == 0);
      end
      phase++;
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (board.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
